FILE: hdl/vdh_pkg.sv
// Shared types and constants of the value dwell histogram monitor.
package vdh_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int IDX_W = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [30:0] TOGGLE_MAX = 31'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGNAL_WIDTH = 2'd0,
    CFG_IS_SIGNED    = 2'd1,
    CFG_PER_VALUE    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic        operation;
    logic [63:0] sample_value;
    logic [63:0] time_now;
    logic [9:0]  bucket_select;
  } in_t;

  typedef struct packed {
    logic        value_changed;
    logic [30:0] toggle_count;
    logic [9:0]  entered_bucket;
    logic [10:0] bucket_count_in_use;
    logic [31:0] read_hits;
    logic [63:0] read_min_time;
    logic [63:0] read_max_time;
    logic [63:0] read_total_time;
  } out_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic [63:0]      diff;
    logic             changed;
    logic [30:0]      toggle;
    logic [9:0]       entered;
    logic [10:0]      count;
  } cmd_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [63:0] total;
    logic [63:0] min_time;
    logic [63:0] max_time;
    logic        min_valid;
  } stat_t;

endpackage

FILE: hdl/vdh_if.sv
// Valid/ready channel interfaces for input and result beats.
interface vdh_in_if;
  logic          valid;
  logic          ready;
  vdh_pkg::in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface vdh_out_if;
  logic          valid;
  logic          ready;
  vdh_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/value_dwell_histogram_monitor_unit.sv
// Top level of the value dwell histogram monitor.
// The in_i channel carries sample or read beats; out_o returns exactly one
// result beat per accepted input beat, in order. Each sample compares the
// masked value with the last one; on a change it counts a toggle and closes
// the current bucket's dwell; a read of a bucket in use returns its statistics.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not enforce.
// Throughput is one beat per cycle while out_o.ready stays high. Without a
// downstream stall, the front end classifies a beat in the accept cycle, the
// command queue hands it to the back end, and the bucket store read is
// registered before the update is written back, with forwarding of the
// last write so that consecutive updates of one bucket stay correct.
// After reset the bucket store is cleared one entry a cycle, all 1024 entries;
// in_i.ready stays low until it finishes.
// When the receiver stalls, the result register holds its beat, the back end
// stops, and the two-entry queue fills before in_i.ready drops.
module value_dwell_histogram_monitor_unit #(
  parameter int MAX_PER_VALUE_BITS = 10,
  parameter int RANGE_BUCKETS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vdh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vdh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  vdh_in_if.sink                         in_i,
  vdh_out_if.source                      out_o
);
  logic          busy, q_full, push, pop, head_valid;
  vdh_pkg::cmd_t cmd, head;

  vdh_front #(
    .MAX_PER_VALUE_BITS (MAX_PER_VALUE_BITS),
    .RANGE_BUCKETS      (RANGE_BUCKETS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_i      (busy),
    .q_full_i    (q_full),
    .in_i        (in_i),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  vdh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  vdh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .busy_o       (busy),
    .out_o        (out_o)
  );
endmodule

FILE: hdl/vdh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hdl/vdh_front.sv
// Front end: configuration, change detection, bucket mapping and command issue.
module vdh_front #(
  parameter int MAX_PER_VALUE_BITS = 10,
  parameter int RANGE_BUCKETS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vdh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vdh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           busy_i,
  input  logic                           q_full_i,
  vdh_in_if.sink                         in_i,
  output logic                           push_o,
  output vdh_pkg::cmd_t                  cmd_o
);
  localparam int L = $clog2(RANGE_BUCKETS);
  localparam int LIM = (MAX_PER_VALUE_BITS < 10) ? MAX_PER_VALUE_BITS : 10;
  localparam int HALF = (RANGE_BUCKETS + 1) / 2;

  logic [6:0]  sig_width_q;
  logic        is_signed_q, per_value_q;
  logic        started_q, started_d;
  logic [63:0] last_value_q, last_value_d;
  logic [30:0] change_total_q, change_total_d;
  logic [9:0]  cur_bucket_q, cur_bucket_d;
  logic [63:0] last_time_q, last_time_d;

  logic [6:0]         w;
  logic               per_value;
  logic [10:0]        n;
  logic [63:0]        mask, v, shifted, diff;
  logic [L-1:0]       top;
  logic signed [11:0] rb;
  logic [10:0]        pv_b, map_b;
  logic               accept, changed;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !busy_i && !q_full_i;

  always_comb begin
    if (sig_width_q == 7'd0) begin
      w = 7'd1;
    end else if (sig_width_q > 7'd64) begin
      w = 7'd64;
    end else begin
      w = sig_width_q;
    end
    per_value = (per_value_q && (w <= 7'(LIM))) || (w <= 7'(L));
    n = per_value ? (11'd1 << w) : 11'(RANGE_BUCKETS + 1);
    mask = (w == 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
    v = in_i.payload.sample_value & mask;
    pv_b = {1'b0, v[9:0]} ^ (is_signed_q ? (11'd1 << (w - 7'd1)) : 11'd0);
    shifted = v >> (w - 7'(L));
    top = shifted[L-1:0];
    if (is_signed_q) begin
      rb = $signed({{(12-L){top[L-1]}}, top}) + 12'sd1 + 12'(HALF);
    end else begin
      rb = $signed(12'(top)) + 12'sd1;
    end
    if (rb < 12'sd0) begin
      rb = 12'sd0;
    end else if (rb > $signed(12'(RANGE_BUCKETS))) begin
      rb = $signed(12'(RANGE_BUCKETS));
    end
    if (per_value) begin
      map_b = pv_b;
    end else if (v == 64'd0) begin
      map_b = is_signed_q ? 11'(HALF) : 11'd0;
    end else begin
      map_b = rb[10:0];
    end
    diff = (in_i.payload.time_now >= last_time_q) ?
           (in_i.payload.time_now - last_time_q) : 64'd0;
    changed = started_q && (v != (last_value_q & mask));

    started_d = started_q;
    last_value_d = last_value_q;
    change_total_d = change_total_q;
    cur_bucket_d = cur_bucket_q;
    last_time_d = last_time_q;
    cmd_o = '0;
    cmd_o.kind = vdh_pkg::CMD_NONE;
    if (in_i.payload.operation == vdh_pkg::OP_SAMPLE) begin
      if (!started_q) begin
        started_d = 1'b1;
        last_value_d = v;
      end else if (changed) begin
        if (change_total_q < vdh_pkg::TOGGLE_MAX) begin
          change_total_d = change_total_q + 31'd1;
        end
        cur_bucket_d = map_b[9:0];
        last_time_d = in_i.payload.time_now;
        last_value_d = v;
        cmd_o.kind = vdh_pkg::CMD_CLOSE;
        cmd_o.idx = cur_bucket_q;
        cmd_o.diff = diff;
      end
    end else if ({1'b0, in_i.payload.bucket_select} < n) begin
      cmd_o.kind = vdh_pkg::CMD_READ;
      cmd_o.idx = in_i.payload.bucket_select;
    end
    cmd_o.changed = (in_i.payload.operation == vdh_pkg::OP_SAMPLE) && changed;
    cmd_o.toggle = change_total_d;
    cmd_o.entered = cur_bucket_d;
    cmd_o.count = n;
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_width_q <= 7'd8;
      is_signed_q <= 1'b0;
      per_value_q <= 1'b0;
      started_q <= 1'b0;
      last_value_q <= '0;
      change_total_q <= '0;
      cur_bucket_q <= '0;
      last_time_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vdh_pkg::CFG_SIGNAL_WIDTH: sig_width_q <= cfg_wdata_i;
          vdh_pkg::CFG_IS_SIGNED:    is_signed_q <= cfg_wdata_i[0];
          vdh_pkg::CFG_PER_VALUE:    per_value_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        started_q <= started_d;
        last_value_q <= last_value_d;
        change_total_q <= change_total_d;
        cur_bucket_q <= cur_bucket_d;
        last_time_q <= last_time_d;
      end
    end
  end
endmodule

FILE: hdl/vdh_queue.sv
// Two-entry command queue between the front and back ends.
module vdh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vdh_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          head_valid_o,
  output vdh_pkg::cmd_t head_o
);
  localparam int PW = $clog2(vdh_pkg::QUEUE_DEPTH);

  vdh_pkg::cmd_t   entry_q [vdh_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [PW:0]     cnt_q;

  assign full_o = (cnt_q == (PW+1)'(vdh_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end
endmodule

FILE: hdl/vdh_back.sv
// Back end: bucket store clearing, read-modify-write with forwarding, result register.
module vdh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  vdh_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          busy_o,
  vdh_out_if.source     out_o
);
  localparam int SW = $bits(vdh_pkg::stat_t);

  logic [vdh_pkg::IDX_W:0]   clr_cnt_q;
  logic                      clearing;
  vdh_pkg::cmd_t             s1_q;
  logic                      s1_valid_q;
  logic                      fwd_valid_q;
  logic [vdh_pkg::IDX_W-1:0] fwd_addr_q;
  vdh_pkg::stat_t            fwd_data_q;
  logic                      out_valid_q;
  vdh_pkg::out_t             out_q, out_d;

  logic                      fire, we;
  logic [vdh_pkg::IDX_W-1:0] waddr;
  vdh_pkg::stat_t            wdata, cur, upd;
  logic [SW-1:0]             rdata;
  logic [64:0]               sum;

  assign clearing = !clr_cnt_q[vdh_pkg::IDX_W];
  assign busy_o = clearing;
  assign fire = s1_valid_q && (!out_valid_q || out_o.ready);
  assign pop_o = head_valid_i && !clearing && (!s1_valid_q || fire);

  vdh_ram #(
    .WIDTH (SW),
    .DEPTH (vdh_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (pop_o),
    .raddr_i (head_i.idx),
    .rdata_o (rdata)
  );

  always_comb begin
    cur = (fwd_valid_q && (fwd_addr_q == s1_q.idx)) ? fwd_data_q : vdh_pkg::stat_t'(rdata);
    upd = cur;
    upd.hits = (cur.hits != '1) ? (cur.hits + 32'd1) : cur.hits;
    sum = {1'b0, cur.total} + {1'b0, s1_q.diff};
    upd.total = sum[64] ? '1 : sum[63:0];
    if (!cur.min_valid || (s1_q.diff < cur.min_time)) begin
      upd.min_time = s1_q.diff;
    end
    upd.min_valid = 1'b1;
    if (s1_q.diff > cur.max_time) begin
      upd.max_time = s1_q.diff;
    end

    out_d = '0;
    out_d.value_changed = s1_q.changed;
    out_d.toggle_count = s1_q.toggle;
    out_d.entered_bucket = s1_q.entered;
    out_d.bucket_count_in_use = s1_q.count;
    if (s1_q.kind == vdh_pkg::CMD_READ) begin
      out_d.read_hits = cur.hits;
      out_d.read_min_time = cur.min_valid ? cur.min_time : 64'd0;
      out_d.read_max_time = cur.max_time;
      out_d.read_total_time = cur.total;
    end

    if (clearing) begin
      we = 1'b1;
      waddr = clr_cnt_q[vdh_pkg::IDX_W-1:0];
      wdata = '0;
    end else begin
      we = fire && (s1_q.kind == vdh_pkg::CMD_CLOSE);
      waddr = s1_q.idx;
      wdata = upd;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= head_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
    if (we && !clearing) begin
      fwd_addr_q <= waddr;
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      s1_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + (vdh_pkg::IDX_W+1)'(1);
      end
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (we && !clearing) begin
        fwd_valid_q <= 1'b1;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s1_valid_q && !pop_o)
    else $error("command in flight during store clearing");
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("completed command produced no result");
  a_write_only_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && !clearing) |-> (fire && s1_q.kind == vdh_pkg::CMD_CLOSE))
    else $error("store written outside a dwell close");
endmodule
